[src/constant_fraction_discriminator_assert.svh]
// ---------------------------------------------------------------------------
// Assertion macros for the constant fraction discriminator
// Each module that checks itself includes this header and states its
// properties through the macros below. Sampled on clk, off during reset.
// ---------------------------------------------------------------------------
`ifndef CONSTANT_FRACTION_DISCRIMINATOR_ASSERT_SVH
`define CONSTANT_FRACTION_DISCRIMINATOR_ASSERT_SVH

// same-cycle implication
`define CFD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CFD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/cfd_pkg.sv]
// ---------------------------------------------------------------------------
// cfd_pkg
// Shared constants for the constant fraction discriminator: field widths,
// register codes, reset values and parameter defaults.
// ---------------------------------------------------------------------------
package cfd_pkg;

  // parameter defaults
  localparam int MAX_DELAY_DEF   = 8;
  localparam int MAX_SAMPLES_DEF = 64;
  localparam int SAMPLE_BITS_DEF = 13;

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;
  localparam int DELAY_W    = 3;
  localparam int FRAC_W     = 8;

  localparam logic [CFG_IDX_W-1:0] REG_DELAY_SAMPLES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRACTION_Q8   = 2'd1;

  localparam logic [DELAY_W-1:0] DELAY_RESET = 3'd1;
  localparam logic [FRAC_W-1:0]  FRAC_RESET  = 8'd26;

  // crossing time: integer sample index plus FRAC_W fraction bits
  localparam int              TIME_W   = 14;
  localparam logic [TIME_W-1:0] TIME_MAX = 14'h3fff;

  localparam int PEAK_IDX_W = 6;

endpackage

[src/constant_fraction_discriminator.sv]
// ---------------------------------------------------------------------------
// constant_fraction_discriminator
// Takes one ADC sample word per clock; the input side waits on the
// interpolation only when the two-entry job queue is full. For each
// waveform it forms 256*s[k-delay] - fraction*s[k],
// finds the first strict negative-to-positive crossing from index delay on,
// tracks the first largest sample, and on the word flagged last issues one
// result word. Crossing time is in 1/256 sample, fraction truncated,
// saturating at 16383; a combined value of exactly zero never forms a
// crossing. Samples past MAX_SAMPLES are ignored but a last flag still ends
// the waveform. Samples stream at one per clock while in_stall is low.
// Each waveform then holds the back end for a load, 8 restoring division
// steps if it has a crossing, and the result, which waits on out_stall,
// so short waveforms fill the queue and raise in_stall. Configuration
// takes effect at once and must be written only while the block is idle.
// ---------------------------------------------------------------------------
module constant_fraction_discriminator #(
  parameter int MAX_DELAY   = cfd_pkg::MAX_DELAY_DEF,
  parameter int MAX_SAMPLES = cfd_pkg::MAX_SAMPLES_DEF,
  parameter int SAMPLE_BITS = cfd_pkg::SAMPLE_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration
  input  logic                              cfg_we,
  input  logic [cfd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [cfd_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  // sample stream
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [SAMPLE_BITS-1:0]     in_sample,
  input  logic                              in_last_sample,
  // results
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_crossing_found,
  output logic [cfd_pkg::TIME_W-1:0]        out_cross_time,
  output logic                              out_peak_valid,
  output logic signed [SAMPLE_BITS-1:0]     out_peak_amplitude,
  output logic [cfd_pkg::PEAK_IDX_W-1:0]    out_peak_index
);

  // combined signal width: sample plus 8 fraction bits plus one growth bit
  localparam int CW    = SAMPLE_BITS + cfd_pkg::FRAC_W + 1;
  localparam int PIDXW = $clog2(MAX_SAMPLES);
  // job word: found, prev, cur, crossing index, peak amplitude, peak index
  localparam int JOB_W = 1 + CW + CW + PIDXW + SAMPLE_BITS + PIDXW;

  logic                          q_full;
  logic                          q_empty;
  logic                          q_pop;
  logic                          f_push;
  logic                          f_found;
  logic signed [CW-1:0]          f_xprev;
  logic signed [CW-1:0]          f_xcur;
  logic [PIDXW-1:0]              f_xk;
  logic signed [SAMPLE_BITS-1:0] f_amp;
  logic [PIDXW-1:0]              f_pos;
  logic [JOB_W-1:0]              q_wdata;
  logic [JOB_W-1:0]              q_rdata;
  logic                          b_found;
  logic signed [CW-1:0]          b_xprev;
  logic signed [CW-1:0]          b_xcur;
  logic [PIDXW-1:0]              b_xk;
  logic signed [SAMPLE_BITS-1:0] b_amp;
  logic [PIDXW-1:0]              b_pos;

  // front stalls only when the job queue is full
  assign in_stall = q_full;

  cfd_front #(
    .MAX_DELAY   (MAX_DELAY),
    .MAX_SAMPLES (MAX_SAMPLES),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_sample      (in_sample),
    .in_last_sample (in_last_sample),
    .q_full         (q_full),
    .job_push       (f_push),
    .job_found      (f_found),
    .job_xprev      (f_xprev),
    .job_xcur       (f_xcur),
    .job_xk         (f_xk),
    .job_amp        (f_amp),
    .job_pos        (f_pos)
  );

  assign q_wdata = {f_found, f_xprev, f_xcur, f_xk, f_amp, f_pos};

  cfd_queue #(
    .WIDTH (JOB_W),
    .DEPTH (cfd_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (f_push),
    .wdata (q_wdata),
    .pop   (q_pop),
    .rdata (q_rdata),
    .full  (q_full),
    .empty (q_empty)
  );

  assign {b_found, b_xprev, b_xcur, b_xk, b_amp, b_pos} = q_rdata;

  cfd_back #(
    .MAX_SAMPLES (MAX_SAMPLES),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk                (clk),
    .rst_n              (rst_n),
    .q_empty            (q_empty),
    .q_pop              (q_pop),
    .job_found          (b_found),
    .job_xprev          (b_xprev),
    .job_xcur           (b_xcur),
    .job_xk             (b_xk),
    .job_amp            (b_amp),
    .job_pos            (b_pos),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_crossing_found (out_crossing_found),
    .out_cross_time     (out_cross_time),
    .out_peak_valid     (out_peak_valid),
    .out_peak_amplitude (out_peak_amplitude),
    .out_peak_index     (out_peak_index)
  );

endmodule

[src/cfd_front.sv]
// ---------------------------------------------------------------------------
// cfd_front
// Stream side: configuration registers, delay line, combined signal, first
// crossing capture and peak tracking. Hands one job per waveform to the queue.
// ---------------------------------------------------------------------------
module cfd_front #(
  parameter int MAX_DELAY   = cfd_pkg::MAX_DELAY_DEF,
  parameter int MAX_SAMPLES = cfd_pkg::MAX_SAMPLES_DEF,
  parameter int SAMPLE_BITS = cfd_pkg::SAMPLE_BITS_DEF,
  localparam int CW         = SAMPLE_BITS + cfd_pkg::FRAC_W + 1,
  localparam int PIDXW      = $clog2(MAX_SAMPLES)
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [cfd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cfd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                            in_valid,
  input  logic signed [SAMPLE_BITS-1:0]   in_sample,
  input  logic                            in_last_sample,
  input  logic                            q_full,
  output logic                            job_push,
  output logic                            job_found,
  output logic signed [CW-1:0]            job_xprev,
  output logic signed [CW-1:0]            job_xcur,
  output logic [PIDXW-1:0]                job_xk,
  output logic signed [SAMPLE_BITS-1:0]   job_amp,
  output logic [PIDXW-1:0]                job_pos
);

  localparam int IDXW     = $clog2(MAX_SAMPLES + 1);
  localparam int DL_DEPTH = MAX_DELAY - 1;
  localparam int DLW      = (DL_DEPTH > 1) ? $clog2(DL_DEPTH) : 1;
  localparam int DW       = cfd_pkg::DELAY_W;

  logic [DW-1:0]                  cfg_delay_r;
  logic [cfd_pkg::FRAC_W-1:0]     cfg_frac_r;

  logic signed [SAMPLE_BITS-1:0]  dline_r   [DL_DEPTH];
  logic signed [SAMPLE_BITS-1:0]  dline_nxt [DL_DEPTH];
  logic signed [CW-1:0]           prev_r, prev_nxt, prev_upd;
  logic [IDXW-1:0]                idx_r, idx_nxt, idx_upd;
  logic                           found_r, found_nxt, found_upd;
  logic signed [CW-1:0]           xprev_r, xprev_nxt, xprev_upd;
  logic signed [CW-1:0]           xcur_r, xcur_nxt, xcur_upd;
  logic [PIDXW-1:0]               xk_r, xk_nxt, xk_upd;
  logic signed [SAMPLE_BITS-1:0]  max_amp_r, max_amp_nxt, max_amp_upd;
  logic [PIDXW-1:0]               max_pos_r, max_pos_nxt, max_pos_upd;

  logic [DW-1:0]                  d_eff;
  logic [DLW-1:0]                 tap;
  logic signed [SAMPLE_BITS-1:0]  delayed;
  logic signed [CW-1:0]           dly_sh;
  logic signed [CW-1:0]           prod;
  logic signed [CW-1:0]           comb;
  logic                           accept;
  logic                           active;
  logic                           hit;
  logic                           peak_up;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_delay_r <= cfd_pkg::DELAY_RESET;
      cfg_frac_r  <= cfd_pkg::FRAC_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        cfd_pkg::REG_DELAY_SAMPLES: cfg_delay_r <= cfg_wdata[DW-1:0];
        cfd_pkg::REG_FRACTION_Q8:   cfg_frac_r  <= cfg_wdata[cfd_pkg::FRAC_W-1:0];
        default: ;
      endcase
    end
  end

  // zero delay acts as one; clamp to the delay line length
  always_comb begin
    d_eff = (cfg_delay_r == '0) ? DW'(1) : cfg_delay_r;
    if (int'(d_eff) > DL_DEPTH) d_eff = DW'(DL_DEPTH);
  end

  assign tap     = DLW'(d_eff - DW'(1));
  assign delayed = dline_r[tap];
  assign dly_sh  = {delayed[SAMPLE_BITS-1], delayed, {cfd_pkg::FRAC_W{1'b0}}};
  assign prod    = in_sample * $signed({1'b0, cfg_frac_r});
  assign comb    = dly_sh - prod;

  assign accept  = in_valid && !q_full;
  assign active  = idx_r < IDXW'(MAX_SAMPLES);
  // strict sign change; exact zero never counts
  assign hit     = active && !found_r && (idx_r >= IDXW'(d_eff)) &&
                   !comb[CW-1] && (comb != '0) && prev_r[CW-1];
  assign peak_up = active && (in_sample > max_amp_r);

  // state after this sample
  always_comb begin
    found_upd   = found_r;
    xprev_upd   = xprev_r;
    xcur_upd    = xcur_r;
    xk_upd      = xk_r;
    max_amp_upd = max_amp_r;
    max_pos_upd = max_pos_r;
    prev_upd    = prev_r;
    idx_upd     = idx_r;
    if (hit) begin
      found_upd = 1'b1;
      xprev_upd = prev_r;
      xcur_upd  = comb;
      xk_upd    = idx_r[PIDXW-1:0];
    end
    if (peak_up) begin
      max_amp_upd = in_sample;
      max_pos_upd = idx_r[PIDXW-1:0];
    end
    if (active) begin
      prev_upd = comb;
      idx_upd  = idx_r + IDXW'(1);
    end
  end

  always_comb begin
    found_nxt   = found_r;
    xprev_nxt   = xprev_r;
    xcur_nxt    = xcur_r;
    xk_nxt      = xk_r;
    max_amp_nxt = max_amp_r;
    max_pos_nxt = max_pos_r;
    prev_nxt    = prev_r;
    idx_nxt     = idx_r;
    dline_nxt   = dline_r;
    if (accept) begin
      xprev_nxt = xprev_upd;
      xcur_nxt  = xcur_upd;
      xk_nxt    = xk_upd;
      if (in_last_sample) begin
        // waveform done: back to the per-waveform reset state
        found_nxt   = 1'b0;
        max_amp_nxt = '1;
        max_pos_nxt = '0;
        prev_nxt    = '0;
        idx_nxt     = '0;
        for (int i = 0; i < DL_DEPTH; i++) dline_nxt[i] = '0;
      end else begin
        found_nxt   = found_upd;
        max_amp_nxt = max_amp_upd;
        max_pos_nxt = max_pos_upd;
        prev_nxt    = prev_upd;
        idx_nxt     = idx_upd;
        if (active) begin
          for (int i = DL_DEPTH - 1; i > 0; i--) dline_nxt[i] = dline_r[i-1];
          dline_nxt[0] = in_sample;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r   <= 1'b0;
      max_amp_r <= '1;
      max_pos_r <= '0;
      prev_r    <= '0;
      idx_r     <= '0;
      for (int i = 0; i < DL_DEPTH; i++) dline_r[i] <= '0;
    end else begin
      found_r   <= found_nxt;
      max_amp_r <= max_amp_nxt;
      max_pos_r <= max_pos_nxt;
      prev_r    <= prev_nxt;
      idx_r     <= idx_nxt;
      dline_r   <= dline_nxt;
    end
  end

  always_ff @(posedge clk) begin
    xprev_r <= xprev_nxt;
    xcur_r  <= xcur_nxt;
    xk_r    <= xk_nxt;
  end

  assign job_push  = accept && in_last_sample;
  assign job_found = found_upd;
  assign job_xprev = xprev_upd;
  assign job_xcur  = xcur_upd;
  assign job_xk    = xk_upd;
  assign job_amp   = max_amp_upd;
  assign job_pos   = max_pos_upd;

endmodule

[src/cfd_queue.sv]
// ---------------------------------------------------------------------------
// cfd_queue
// Small flop FIFO carrying one job word per waveform from front to back.
// ---------------------------------------------------------------------------
`include "constant_fraction_discriminator_assert.svh"

module cfd_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = cfd_pkg::QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             full,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CNTW-1:0]  count_r, count_nxt;

  assign full  = count_r == CNTW'(DEPTH);
  assign empty = count_r == '0;
  assign rdata = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    if (pop)  rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    if (push && !pop) count_nxt = count_r + CNTW'(1);
    if (pop && !push) count_nxt = count_r - CNTW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= wdata;
  end

  `CFD_ASSERT_IMP(a_q_no_overflow, push, !full, "queue push while full")
  `CFD_ASSERT_IMP(a_q_no_underflow, pop, !empty, "queue pop while empty")
  `CFD_ASSERT_NXT(a_q_count_up, push && !pop, count_r == $past(count_r) + CNTW'(1), "queue count did not rise")

endmodule

[src/cfd_back.sv]
// ---------------------------------------------------------------------------
// cfd_back
// Job side: interpolation by restoring division (one quotient bit a cycle),
// time saturation, and the output register.
// ---------------------------------------------------------------------------
`include "constant_fraction_discriminator_assert.svh"

module cfd_back #(
  parameter int MAX_SAMPLES = cfd_pkg::MAX_SAMPLES_DEF,
  parameter int SAMPLE_BITS = cfd_pkg::SAMPLE_BITS_DEF,
  localparam int CW         = SAMPLE_BITS + cfd_pkg::FRAC_W + 1,
  localparam int PIDXW      = $clog2(MAX_SAMPLES)
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                q_empty,
  output logic                                q_pop,
  input  logic                                job_found,
  input  logic signed [CW-1:0]                job_xprev,
  input  logic signed [CW-1:0]                job_xcur,
  input  logic [PIDXW-1:0]                    job_xk,
  input  logic signed [SAMPLE_BITS-1:0]       job_amp,
  input  logic [PIDXW-1:0]                    job_pos,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                out_crossing_found,
  output logic [cfd_pkg::TIME_W-1:0]          out_cross_time,
  output logic                                out_peak_valid,
  output logic signed [SAMPLE_BITS-1:0]       out_peak_amplitude,
  output logic [cfd_pkg::PEAK_IDX_W-1:0]      out_peak_index
);

  localparam int QW   = cfd_pkg::FRAC_W;
  localparam int CNTW = $clog2(QW);
  localparam int TW   = (PIDXW + QW > cfd_pkg::TIME_W) ? PIDXW + QW : cfd_pkg::TIME_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]                    state_r, state_nxt;
  logic [CNTW-1:0]               cnt_r, cnt_nxt;
  logic [CW-1:0]                 rem_r, rem_nxt;
  logic [CW-1:0]                 den_r, den_nxt;
  logic [QW-1:0]                 quo_r, quo_nxt;
  logic                          found_r, found_nxt;
  logic [PIDXW-1:0]              k_r, k_nxt;
  logic signed [SAMPLE_BITS-1:0] amp_r, amp_nxt;
  logic [PIDXW-1:0]              pos_r, pos_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic                          out_found_r;
  logic [cfd_pkg::TIME_W-1:0]    out_time_r;
  logic                          out_pv_r;
  logic signed [SAMPLE_BITS-1:0] out_amp_r;
  logic [cfd_pkg::PEAK_IDX_W-1:0] out_idx_r;

  logic [CW:0]                   shifted;
  logic                          ge;
  logic [PIDXW-1:0]              k_m1;
  logic [TW-1:0]                 t_wide;
  logic [cfd_pkg::TIME_W-1:0]    t_sat;
  logic                          out_load;
  logic                          pv;

  assign shifted = {rem_r, 1'b0};
  assign ge      = shifted >= {1'b0, den_r};

  // time = (k - 1) * 256 + quotient, saturated
  assign k_m1   = k_r - PIDXW'(1);
  assign t_wide = TW'({k_m1, quo_r});
  assign t_sat  = (t_wide > TW'(cfd_pkg::TIME_MAX)) ? cfd_pkg::TIME_MAX
                                                    : cfd_pkg::TIME_W'(t_wide);

  assign pv       = !amp_r[SAMPLE_BITS-1];
  assign q_pop    = (state_r == ST_IDLE) && !q_empty;
  assign out_load = (state_r == ST_DONE) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    rem_nxt   = rem_r;
    den_nxt   = den_r;
    quo_nxt   = quo_r;
    found_nxt = found_r;
    k_nxt     = k_r;
    amp_nxt   = amp_r;
    pos_nxt   = pos_r;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          found_nxt = job_found;
          k_nxt     = job_xk;
          amp_nxt   = job_amp;
          pos_nxt   = job_pos;
          // prev < 0 < cur: magnitude of prev is below the span
          rem_nxt   = -job_xprev;
          den_nxt   = job_xcur - job_xprev;
          quo_nxt   = '0;
          cnt_nxt   = '0;
          state_nxt = job_found ? ST_DIV : ST_DONE;
        end
      end
      ST_DIV: begin
        rem_nxt = ge ? CW'(shifted - {1'b0, den_r}) : shifted[CW-1:0];
        quo_nxt = {quo_r[QW-2:0], ge};
        cnt_nxt = cnt_r + CNTW'(1);
        if (cnt_r == CNTW'(QW - 1)) state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (out_load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
    if (out_load) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r   <= cnt_nxt;
    rem_r   <= rem_nxt;
    den_r   <= den_nxt;
    quo_r   <= quo_nxt;
    found_r <= found_nxt;
    k_r     <= k_nxt;
    amp_r   <= amp_nxt;
    pos_r   <= pos_nxt;
    if (out_load) begin
      out_found_r <= found_r;
      out_time_r  <= found_r ? t_sat : '0;
      out_pv_r    <= pv;
      out_amp_r   <= amp_r;
      out_idx_r   <= pv ? cfd_pkg::PEAK_IDX_W'(pos_r) : '0;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_crossing_found = out_found_r;
  assign out_cross_time     = out_time_r;
  assign out_peak_valid     = out_pv_r;
  assign out_peak_amplitude = out_amp_r;
  assign out_peak_index     = out_idx_r;

  `CFD_ASSERT_IMP(a_div_rem_below_den, state_r == ST_DIV, rem_r < den_r, "remainder >= divisor")
  `CFD_ASSERT_IMP(a_no_time_wo_cross, out_valid_r && !out_found_r, out_time_r == '0, "stray time")

endmodule

[sim/cfd_checker.sv]
// ---------------------------------------------------------------------------
// cfd_checker
// Watches the config port and both word channels of the constant fraction
// discriminator, predicts one result word per waveform and compares each
// accepted result word, field by field, with the oldest prediction.
// ---------------------------------------------------------------------------
module cfd_checker (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  logic                                       cfg_we,
  input  logic [cfd_pkg::CFG_IDX_W-1:0]              cfg_index,
  input  logic [cfd_pkg::CFG_DATA_W-1:0]             cfg_wdata,
  input  logic                                       in_valid,
  input  logic                                       in_stall,
  input  logic signed [cfd_pkg::SAMPLE_BITS_DEF-1:0] in_sample,
  input  logic                                       in_last_sample,
  input  logic                                       out_valid,
  input  logic                                       out_stall,
  input  logic                                       out_crossing_found,
  input  logic [cfd_pkg::TIME_W-1:0]                 out_cross_time,
  input  logic                                       out_peak_valid,
  input  logic signed [cfd_pkg::SAMPLE_BITS_DEF-1:0] out_peak_amplitude,
  input  logic [cfd_pkg::PEAK_IDX_W-1:0]             out_peak_index,
  output int                                         fail_count,
  output int                                         outstanding,
  output int                                         results_checked,
  output int                                         crossings_seen
);

  localparam int SAMPLE_W = cfd_pkg::SAMPLE_BITS_DEF;

  typedef struct {
    logic                              found;
    logic [cfd_pkg::TIME_W-1:0]        cross_time;
    logic                              peak_valid;
    logic signed [SAMPLE_W-1:0]        peak_amplitude;
    logic [cfd_pkg::PEAK_IDX_W-1:0]    peak_index;
  } cfd_result_t;

  cfd_result_t expected_q[$];

  // register shadows
  logic [cfd_pkg::DELAY_W-1:0] delay_reg;
  logic [cfd_pkg::FRAC_W-1:0]  frac_reg;

  // per-waveform state
  logic signed [SAMPLE_W-1:0]        taps [cfd_pkg::MAX_DELAY_DEF];
  logic signed [21:0]                prev_comb;
  logic [6:0]                        sample_idx;   // saturates at MAX_SAMPLES
  logic                              found;
  logic [cfd_pkg::TIME_W-1:0]        cross_reg;
  logic signed [SAMPLE_W-1:0]        peak_amp;
  logic [cfd_pkg::PEAK_IDX_W-1:0]    peak_pos;

  int fails;
  int checked;
  int crossings;

  task automatic clear_waveform();
    int i;
    for (i = 0; i < cfd_pkg::MAX_DELAY_DEF; i++) taps[i] = '0;
    prev_comb  = '0;
    sample_idx = '0;
    found      = 1'b0;
    cross_reg  = '0;
    peak_amp   = -1;
    peak_pos   = '0;
  endtask

  // One sample through the discriminator; queues a result word on the last.
  task automatic advance_waveform(input logic signed [SAMPLE_W-1:0] s,
                                  input logic is_last);
    int unsigned d;
    int comb;
    int num;
    int den;
    int t;
    int i;
    cfd_result_t r;
    d = (delay_reg == 0) ? 1 : int'(delay_reg);
    if (sample_idx < cfd_pkg::MAX_SAMPLES_DEF) begin
      comb = int'(taps[d-1]) * 256 - int'(frac_reg) * int'(s);
      // strict sign change only: a zero never counts on either side
      if (!found && sample_idx >= d && comb > 0 && prev_comb < 0) begin
        num = -int'(prev_comb) * 256;
        den = comb - int'(prev_comb);
        t   = (int'(sample_idx) - 1) * 256 + num / den;
        cross_reg = (t > int'(cfd_pkg::TIME_MAX)) ? cfd_pkg::TIME_MAX
                                                  : t[cfd_pkg::TIME_W-1:0];
        found     = 1'b1;
      end
      if (s > peak_amp) begin
        peak_amp = s;
        peak_pos = sample_idx[cfd_pkg::PEAK_IDX_W-1:0];
      end
      prev_comb = comb[21:0];
      for (i = cfd_pkg::MAX_DELAY_DEF - 1; i > 0; i--) taps[i] = taps[i-1];
      taps[0]    = s;
      sample_idx = sample_idx + 1'b1;
    end
    if (is_last) begin
      r.found          = found;
      r.cross_time     = found ? cross_reg : '0;
      r.peak_valid     = (peak_amp >= 0);
      r.peak_amplitude = peak_amp;
      r.peak_index     = (peak_amp >= 0) ? peak_pos : '0;
      expected_q = {expected_q, r};
      clear_waveform();
    end
  endtask

  task automatic check_field(input string field, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      fails++;
    end
  endtask

  always @(posedge clk) begin
    cfd_result_t e;
    if (!rst_n) begin
      delay_reg = cfd_pkg::DELAY_RESET;
      frac_reg  = cfd_pkg::FRAC_RESET;
      clear_waveform();
      expected_q.delete();
      fails     = 0;
      checked   = 0;
      crossings = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          cfd_pkg::REG_DELAY_SAMPLES: delay_reg = cfg_wdata[cfd_pkg::DELAY_W-1:0];
          cfd_pkg::REG_FRACTION_Q8:   frac_reg  = cfg_wdata[cfd_pkg::FRAC_W-1:0];
          default: ;
        endcase
      end
      // results first, so a word cannot match a prediction made this edge
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          $error("result word with no prediction pending");
          fails++;
        end else begin
          e = expected_q.pop_front();
          checked++;
          if (e.found) crossings++;
          check_field("crossing_found", e.found, out_crossing_found);
          check_field("crossing time", e.cross_time, out_cross_time);
          check_field("peak_valid", e.peak_valid, out_peak_valid);
          check_field("peak_amplitude", e.peak_amplitude, out_peak_amplitude);
          check_field("peak_index", e.peak_index, out_peak_index);
        end
      end
      if (in_valid && !in_stall) advance_waveform(in_sample, in_last_sample);
    end
    fail_count      <= fails;
    outstanding     <= expected_q.size();
    results_checked <= checked;
    crossings_seen  <= crossings;
  end

endmodule

[sim/constant_fraction_discriminator_tb.sv]
// ---------------------------------------------------------------------------
// constant_fraction_discriminator_tb
// Stimulus and verdict for the constant fraction discriminator. A directed
// set of short waveforms hits the sample extremes, a zero combined value,
// all-negative and one-sample waveforms and the delay extremes; then six
// random phases of shaped pulses, raw noise and near-zero waveforms run
// under different register settings and idle patterns. cfd_checker does
// all prediction and comparison.
// ---------------------------------------------------------------------------
module constant_fraction_discriminator_tb;

  localparam int SAMPLE_W = cfd_pkg::SAMPLE_BITS_DEF;

  // settle time for the back end to finish the two jobs it can have queued
  localparam int SETTLE_CYCLES  = 40;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_COUNT    = 6;
  localparam int PHASE_ITEMS    = 200;

  // indexes past the register list; writes there must do nothing
  localparam logic [cfd_pkg::CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
  localparam logic [cfd_pkg::CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

  logic                               clk            = 1'b0;
  logic                               rst_n          = 1'b0;
  logic                               cfg_we         = 1'b0;
  logic [cfd_pkg::CFG_IDX_W-1:0]      cfg_index      = '0;
  logic [cfd_pkg::CFG_DATA_W-1:0]     cfg_wdata      = '0;
  logic                               in_valid       = 1'b0;
  logic                               in_stall;
  logic signed [SAMPLE_W-1:0]         in_sample      = '0;
  logic                               in_last_sample = 1'b0;
  logic                               out_valid;
  logic                               out_stall      = 1'b0;
  logic                               out_crossing_found;
  logic [cfd_pkg::TIME_W-1:0]         out_cross_time;
  logic                               out_peak_valid;
  logic signed [SAMPLE_W-1:0]         out_peak_amplitude;
  logic [cfd_pkg::PEAK_IDX_W-1:0]     out_peak_index;

  int fail_count;
  int outstanding;
  int results_checked;
  int crossings_seen;

  int sender_idle_pct = 30;
  int recv_stall_pct  = 48;
  int stuck_cycles    = 0;
  int samples_sent    = 0;
  int settings_used   = 0;

  int wave_q[$];   // samples of the next waveform

  // delay/fraction per random phase; the fifth phase draws its own
  int phase_delay [PHASE_COUNT] = '{3, 7, 1, 0, 0, 2};
  int phase_frac  [PHASE_COUNT] = '{128, 255, 0, 26, 0, 200};

  always #10 clk = ~clk;

  constant_fraction_discriminator DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_sample          (in_sample),
    .in_last_sample     (in_last_sample),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_crossing_found (out_crossing_found),
    .out_cross_time     (out_cross_time),
    .out_peak_valid     (out_peak_valid),
    .out_peak_amplitude (out_peak_amplitude),
    .out_peak_index     (out_peak_index)
  );

  cfd_checker u_checker (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_sample          (in_sample),
    .in_last_sample     (in_last_sample),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_crossing_found (out_crossing_found),
    .out_cross_time     (out_cross_time),
    .out_peak_valid     (out_peak_valid),
    .out_peak_amplitude (out_peak_amplitude),
    .out_peak_index     (out_peak_index),
    .fail_count         (fail_count),
    .outstanding        (outstanding),
    .results_checked    (results_checked),
    .crossings_seen     (crossings_seen)
  );

  // Receiver: stalls each cycle at the phase rate.
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Watchdog: too long without any word moving on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no word accepted for %0d cycles", WATCHDOG_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // One sample word. Idle cycles come one at a time at the phase rate,
  // each with valid low, before the word is offered.
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] value,
                             input logic is_last);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_sample      <= value;
    in_last_sample <= is_last;
    do @(posedge clk); while (in_stall);
    samples_sent++;
  endtask

  task automatic send_waveform();
    int k;
    for (k = 0; k < wave_q.size(); k++) begin
      send_sample(SAMPLE_W'(wave_q[k]), k == wave_q.size() - 1);
    end
  endtask

  // Hold off the sender until every predicted result word is back; with
  // settle set, also give the back end time to go fully idle.
  task automatic wait_results_drained(input bit settle);
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    if (settle) repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Delay, a spare index, then fraction. Delay data carries random upper
  // bits that the register must drop.
  task automatic apply_config(input int delay, input int frac);
    cfg_we    <= 1'b1;
    cfg_index <= cfd_pkg::REG_DELAY_SAMPLES;
    cfg_wdata <= {5'($urandom_range(31)), 3'(delay)};
    @(posedge clk);
    cfg_index <= $urandom_range(1) ? REG_SPARE_2 : REG_SPARE_3;
    cfg_wdata <= 8'($urandom_range(255));
    @(posedge clk);
    cfg_index <= cfd_pkg::REG_FRACTION_Q8;
    cfg_wdata <= 8'(frac);
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // Random waveform: mostly triangular pulses on small noise, some raw
  // full-range noise, some near-zero data where the combined value ties
  // at zero. A few run past 64 samples.
  task automatic build_waveform();
    int len;
    int pick;
    int kind;
    int t0;
    int rise;
    int fall;
    int amp;
    int v;
    int k;
    pick = $urandom_range(99);
    if (pick < 6)       len = $urandom_range(60, 72);
    else if (pick < 15) len = $urandom_range(1, 3);
    else                len = $urandom_range(4, 24);
    kind = $urandom_range(99);
    amp  = $urandom_range(1, 4095);
    if ($urandom_range(9) == 0) amp = -amp;
    t0   = $urandom_range(0, len / 2);
    rise = $urandom_range(1, 4);
    fall = $urandom_range(1, 8);
    wave_q.delete();
    for (k = 0; k < len; k++) begin
      if (kind < 70) begin
        v = int'($urandom_range(0, 6)) - 3;
        if (k >= t0 && k < t0 + rise)
          v += amp * (k - t0 + 1) / rise;
        else if (k >= t0 + rise && k < t0 + rise + fall)
          v += amp - amp * (k - t0 - rise + 1) / fall;
      end else if (kind < 85) begin
        v = int'($urandom_range(0, 8191)) - 4096;
      end else begin
        v = int'($urandom_range(0, 6)) - 3;
      end
      if (v > 4095)  v = 4095;
      if (v < -4096) v = -4096;
      wave_q = {wave_q, v};
    end
  endtask

  initial begin
    int p;
    int phase_items;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    settings_used = 1;

    // --- directed, reset settings (delay 1, fraction 26) ---
    // crossing between index 1 and 2, then both sample extremes
    wave_q = {0, 100, 50, 4095, -4096};
    send_waveform();
    // nothing above -1: no peak
    wave_q = {-1, -4096, -5};
    send_waveform();
    // combined value exactly zero at index 2 blocks the crossing after it
    wave_q = {0, 13, 128, 0, 0};
    send_waveform();
    // single-sample waveform
    wave_q = {7};
    send_waveform();

    // delay zero acts as one; full fraction
    wait_results_drained(1'b1);
    apply_config(0, 255);
    wave_q = {0, 4095, -4096, 4095};
    send_waveform();

    // longest delay, zero fraction: crossing decided by the delayed copy
    wait_results_drained(1'b1);
    apply_config(7, 0);
    wave_q = {-10, 20, 0, 0, 0, 0, 0, 0, 5};
    send_waveform();

    // --- random phases ---
    for (p = 0; p < PHASE_COUNT; p++) begin
      wait_results_drained(1'b1);
      if (p == 4) apply_config($urandom_range(7), $urandom_range(255));
      else        apply_config(phase_delay[p], phase_frac[p]);
      if (p < 2) begin
        sender_idle_pct = 30;
        recv_stall_pct  = 48;
      end else if (p < 4) begin
        sender_idle_pct = 48;
        recv_stall_pct  = 30;
      end else begin
        sender_idle_pct = 0;
        recv_stall_pct  = 0;
      end
      phase_items = 0;
      while (phase_items < PHASE_ITEMS) begin
        build_waveform();
        phase_items += wave_q.size();
        send_waveform();
        if ($urandom_range(24) == 0) wait_results_drained(1'b0);
      end
    end

    wait_results_drained(1'b1);
    $display("Covered %0d samples, %0d waveforms checked (%0d with a crossing),",
             samples_sent, results_checked, crossings_seen);
    $display("under %0d register settings and three idle patterns.", settings_used);
    if (fail_count == 0 && outstanding == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[constant_fraction_discriminator.f]
+incdir+src
src/cfd_pkg.sv
src/cfd_front.sv
src/cfd_queue.sv
src/cfd_back.sv
src/constant_fraction_discriminator.sv
sim/cfd_checker.sv
sim/constant_fraction_discriminator_tb.sv
